### rtl/core/zero_velocity_update_integrator_macros.svh
// Assertion macros for the zero-velocity-update integrator RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef ZERO_VELOCITY_UPDATE_INTEGRATOR_MACROS_SVH
`define ZERO_VELOCITY_UPDATE_INTEGRATOR_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ZVUI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ZVUI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/zvui_pkg.sv
// Package for the zero-velocity-update integrator: register codes, reset values,
// fixed widths and the queue status type. Depends on nothing.
`default_nettype none

package zvui_pkg;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_LIMIT = 2'd0,
    REG_GYRO_LIMIT  = 2'd1,
    REG_VEL_GAIN    = 2'd2
  } reg_idx_t;

  // Fixed field widths.
  localparam int LIMIT_W   = 15;
  localparam int GAIN_W    = 16;
  localparam int ELAPSED_W = 16;
  localparam int SCALE_W   = ELAPSED_W + GAIN_W;
  localparam int SPEED_W   = 32;

  // Register reset values.
  localparam logic [LIMIT_W-1:0] ACCEL_LIMIT_RST = 15'd21;
  localparam logic [LIMIT_W-1:0] GYRO_LIMIT_RST  = 15'd16;
  localparam logic [GAIN_W-1:0]  VEL_GAIN_RST    = 16'd10283;

  // Square root unit: one result bit per cycle over a 64-bit radicand.
  localparam int ROOT_W     = 2 * SPEED_W;
  localparam int ROOT_STEPS = SPEED_W;
  localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);

  // Request queue between front and back.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

### rtl/core/zero_velocity_update_integrator.sv
// Zero-velocity-update integrator: one result per sample. Samples go through
// the back one at a time, paced by the 32-step bit-serial square root; a
// two-entry queue takes new samples meanwhile. Synchronous active-low reset
// clears velocities, queue and registers.
`default_nettype none

module zero_velocity_update_integrator
  import zvui_pkg::*;
#(
  parameter int VEL_WIDTH    = 32,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire  logic                           clk,
  input  wire  logic                           rst_n,
  input  wire  logic                           in_valid,
  output logic                                 in_ready,
  input  wire  logic signed [SAMPLE_WIDTH-1:0] in_accel_x,
  input  wire  logic signed [SAMPLE_WIDTH-1:0] in_accel_y,
  input  wire  logic signed [SAMPLE_WIDTH-1:0] in_gyro_x,
  input  wire  logic signed [SAMPLE_WIDTH-1:0] in_gyro_y,
  input  wire  logic signed [SAMPLE_WIDTH-1:0] in_gyro_z,
  input  wire  logic        [ELAPSED_W-1:0]    in_interval_ms,
  output logic                                 out_valid,
  input  wire  logic                           out_ready,
  output logic signed [VEL_WIDTH-1:0]          out_velocity_x,
  output logic signed [VEL_WIDTH-1:0]          out_velocity_y,
  output logic        [SPEED_W-1:0]            out_speed,
  output logic                                 out_still,
  input  wire  logic                           cfg_valid,
  output logic                                 cfg_ready,
  input  wire  logic        [CFG_IDX_W-1:0]    cfg_index,
  input  wire  logic        [CFG_DATA_W-1:0]   cfg_data
);

  localparam int Q_W = 1 + 2 * SAMPLE_WIDTH + SCALE_W;

  logic           q_push;
  logic           q_pop;
  logic [Q_W-1:0] q_push_data;
  logic [Q_W-1:0] q_pop_data;
  q_stat_t        q_stat;

  // Accept, classify and scale each sample.
  zvui_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .Q_W         (Q_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_accel_x    (in_accel_x),
    .in_accel_y    (in_accel_y),
    .in_gyro_x     (in_gyro_x),
    .in_gyro_y     (in_gyro_y),
    .in_gyro_z     (in_gyro_z),
    .in_interval_ms(in_interval_ms),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_push        (q_push),
    .q_data        (q_push_data),
    .q_stat        (q_stat)
  );

  // Request queue decoupling the two halves.
  zvui_queue #(
    .DATA_W(Q_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_push_data),
    .pop      (q_pop),
    .pop_data (q_pop_data),
    .stat     (q_stat)
  );

  // Integrate, compute speed and present the result.
  zvui_back #(
    .VEL_WIDTH   (VEL_WIDTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .Q_W         (Q_W)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_data        (q_pop_data),
    .q_stat        (q_stat),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_velocity_x(out_velocity_x),
    .out_velocity_y(out_velocity_y),
    .out_speed     (out_speed),
    .out_still     (out_still)
  );

endmodule

`default_nettype wire

### rtl/core/zvui_queue.sv
// Two-entry request queue between the front and back of the integrator.
// Depends on zvui_pkg for depth and the status type.
`default_nettype none

module zvui_queue
  import zvui_pkg::*;
#(
  parameter int DATA_W = 65
) (
  input  wire  logic              clk,
  input  wire  logic              rst_n,
  input  wire  logic              push,
  input  wire  logic [DATA_W-1:0] push_data,
  input  wire  logic              pop,
  output logic       [DATA_W-1:0] pop_data,
  output q_stat_t                 stat
);

  logic [DATA_W-1:0]  entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;

  // Status and head of the queue.
  assign stat.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (count_r == '0);
  assign pop_data   = entry_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/zvui_front.sv
// Front of the integrator: configuration registers, still detection and
// time scaling of each sample into a queue request. Depends on zvui_pkg.
`default_nettype none

module zvui_front
  import zvui_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int Q_W          = 1 + 2 * SAMPLE_WIDTH + SCALE_W
) (
  input  wire  logic                           clk,
  input  wire  logic                           rst_n,
  input  wire  logic                           in_valid,
  output logic                                 in_ready,
  input  wire  logic signed [SAMPLE_WIDTH-1:0] in_accel_x,
  input  wire  logic signed [SAMPLE_WIDTH-1:0] in_accel_y,
  input  wire  logic signed [SAMPLE_WIDTH-1:0] in_gyro_x,
  input  wire  logic signed [SAMPLE_WIDTH-1:0] in_gyro_y,
  input  wire  logic signed [SAMPLE_WIDTH-1:0] in_gyro_z,
  input  wire  logic        [ELAPSED_W-1:0]    in_interval_ms,
  input  wire  logic                           cfg_valid,
  output logic                                 cfg_ready,
  input  wire  logic        [CFG_IDX_W-1:0]    cfg_index,
  input  wire  logic        [CFG_DATA_W-1:0]   cfg_data,
  output logic                                 q_push,
  output logic              [Q_W-1:0]          q_data,
  input  wire  q_stat_t                        q_stat
);

  localparam int CMP_W = (SAMPLE_WIDTH > LIMIT_W) ? SAMPLE_WIDTH : LIMIT_W;

  logic [LIMIT_W-1:0]   accel_limit_r;
  logic [LIMIT_W-1:0]   gyro_limit_r;
  logic [GAIN_W-1:0]    gain_r;
  logic [CMP_W-1:0]     accel_lim_ext;
  logic [CMP_W-1:0]     gyro_lim_ext;
  logic                 still;
  logic [ELAPSED_W-1:0] ms_eff;
  logic [SCALE_W-1:0]   scale;

  // Absolute value; the most negative code maps to its true magnitude.
  function automatic logic [SAMPLE_WIDTH-1:0] mag_of(
    input logic [SAMPLE_WIDTH-1:0] v
  );
    return v[SAMPLE_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_limit_r <= ACCEL_LIMIT_RST;
      gyro_limit_r  <= GYRO_LIMIT_RST;
      gain_r        <= VEL_GAIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ACCEL_LIMIT: accel_limit_r <= cfg_data[LIMIT_W-1:0];
        REG_GYRO_LIMIT:  gyro_limit_r  <= cfg_data[LIMIT_W-1:0];
        REG_VEL_GAIN:    gain_r        <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Still detection: every magnitude strictly below its limit.
  assign accel_lim_ext = CMP_W'(accel_limit_r);
  assign gyro_lim_ext  = CMP_W'(gyro_limit_r);

  assign still = (CMP_W'(mag_of(in_accel_x)) < accel_lim_ext)
              && (CMP_W'(mag_of(in_accel_y)) < accel_lim_ext)
              && (CMP_W'(mag_of(in_gyro_x))  < gyro_lim_ext)
              && (CMP_W'(mag_of(in_gyro_y))  < gyro_lim_ext)
              && (CMP_W'(mag_of(in_gyro_z))  < gyro_lim_ext);

  // Time scale: a zero interval counts as one millisecond.
  assign ms_eff = (in_interval_ms == '0) ? ELAPSED_W'(1) : in_interval_ms;
  assign scale  = ms_eff * gain_r;

  // Hand the classified sample to the back through the queue.
  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && !q_stat.full;
  assign q_data   = {still, in_accel_x, in_accel_y, scale};

endmodule

`default_nettype wire

### rtl/core/zvui_back.sv
// Back of the integrator: velocity update with saturation, speed by a
// bit-serial square root, and the result register. Depends on zvui_pkg.
`default_nettype none

module zvui_back
  import zvui_pkg::*;
#(
  parameter int VEL_WIDTH    = 32,
  parameter int SAMPLE_WIDTH = 16,
  parameter int Q_W          = 1 + 2 * SAMPLE_WIDTH + SCALE_W
) (
  input  wire  logic                        clk,
  input  wire  logic                        rst_n,
  input  wire  logic              [Q_W-1:0] q_data,
  input  wire  q_stat_t                     q_stat,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire  logic                        out_ready,
  output logic signed [VEL_WIDTH-1:0]       out_velocity_x,
  output logic signed [VEL_WIDTH-1:0]       out_velocity_y,
  output logic        [SPEED_W-1:0]         out_speed,
  output logic                              out_still
);

  `include "zero_velocity_update_integrator_macros.svh"

  localparam int PROD_W = SAMPLE_WIDTH + SCALE_W + 1;
  localparam int INC_W  = PROD_W - 16;
  localparam int SUM_W  = ((VEL_WIDTH > INC_W) ? VEL_WIDTH : INC_W) + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_SQ,
    ST_SUM,
    ST_ROOT,
    ST_DONE
  } state_t;

  state_t                         st_r;
  logic                           still_r;
  logic signed [SAMPLE_WIDTH-1:0] ax_r;
  logic signed [SAMPLE_WIDTH-1:0] ay_r;
  logic        [SCALE_W-1:0]      scale_r;
  logic signed [PROD_W-1:0]       px_r;
  logic signed [PROD_W-1:0]       py_r;
  logic signed [VEL_WIDTH-1:0]    vel_x_r;
  logic signed [VEL_WIDTH-1:0]    vel_y_r;
  logic        [ROOT_W-1:0]       sqx_r;
  logic        [ROOT_W-1:0]       sqy_r;
  logic                           big_r;
  logic                           sat_r;
  logic        [ROOT_W-1:0]       rem_r;
  logic        [ROOT_W-1:0]       root_r;
  logic        [ROOT_W-1:0]       bit_r;
  logic        [ROOT_CNT_W-1:0]   cnt_r;
  logic                           out_valid_r;
  logic signed [VEL_WIDTH-1:0]    out_vx_r;
  logic signed [VEL_WIDTH-1:0]    out_vy_r;
  logic        [SPEED_W-1:0]      out_speed_r;
  logic                           out_still_r;

  logic signed [PROD_W-1:0]    px_nxt;
  logic signed [PROD_W-1:0]    py_nxt;
  logic        [INC_W-1:0]     inc_x;
  logic        [INC_W-1:0]     inc_y;
  logic        [SUM_W-1:0]     sum_x;
  logic        [SUM_W-1:0]     sum_y;
  logic        [VEL_WIDTH-1:0] mag_x;
  logic        [VEL_WIDTH-1:0] mag_y;
  logic        [ROOT_W-1:0]    mag_x_w;
  logic        [ROOT_W-1:0]    mag_y_w;
  logic        [ROOT_W:0]      sq_sum;
  logic        [ROOT_W-1:0]    trial;
  logic                        take;
  logic                        out_free;

  // Clamp a widened sum to the signed velocity range.
  function automatic logic [VEL_WIDTH-1:0] clamp(input logic [SUM_W-1:0] s);
    if ((&s[SUM_W-1:VEL_WIDTH-1]) || !(|s[SUM_W-1:VEL_WIDTH-1])) begin
      return s[VEL_WIDTH-1:0];
    end else if (s[SUM_W-1]) begin
      return {1'b1, {(VEL_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(VEL_WIDTH-1){1'b1}}};
    end
  endfunction

  // Request pops only when the sequencer is free.
  assign q_pop = (st_r == ST_IDLE) && !q_stat.empty;

  // Velocity increments; the dropped low bits give a floor shift.
  assign px_nxt = ax_r * $signed({1'b0, scale_r});
  assign py_nxt = ay_r * $signed({1'b0, scale_r});
  assign inc_x  = px_r[PROD_W-1:16];
  assign inc_y  = py_r[PROD_W-1:16];
  assign sum_x  = {{(SUM_W-VEL_WIDTH){vel_x_r[VEL_WIDTH-1]}}, vel_x_r}
                + {{(SUM_W-INC_W){inc_x[INC_W-1]}}, inc_x};
  assign sum_y  = {{(SUM_W-VEL_WIDTH){vel_y_r[VEL_WIDTH-1]}}, vel_y_r}
                + {{(SUM_W-INC_W){inc_y[INC_W-1]}}, inc_y};

  // Magnitudes for the speed; anything past 32 bits saturates the speed.
  assign mag_x   = vel_x_r[VEL_WIDTH-1] ? (~vel_x_r + 1'b1) : vel_x_r;
  assign mag_y   = vel_y_r[VEL_WIDTH-1] ? (~vel_y_r + 1'b1) : vel_y_r;
  assign mag_x_w = ROOT_W'(mag_x);
  assign mag_y_w = ROOT_W'(mag_y);
  assign sq_sum  = {1'b0, sqx_r} + {1'b0, sqy_r};

  // One square root step: try the next result bit.
  assign trial = root_r + bit_r;
  assign take  = (rem_r >= trial);

  assign out_free = !out_valid_r || out_ready;

  // Sequencer, accumulators and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      vel_x_r     <= '0;
      vel_y_r     <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      // The result stays valid until taken; a finished one loads a free slot.
      out_valid_r <= ((st_r == ST_DONE) && out_free) || (out_valid_r && !out_ready);
      unique case (st_r)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            still_r <= q_data[Q_W-1];
            ax_r    <= q_data[SCALE_W+SAMPLE_WIDTH +: SAMPLE_WIDTH];
            ay_r    <= q_data[SCALE_W +: SAMPLE_WIDTH];
            scale_r <= q_data[SCALE_W-1:0];
            st_r    <= ST_MUL;
          end
        end
        ST_MUL: begin
          px_r <= px_nxt;
          py_r <= py_nxt;
          st_r <= ST_ACC;
        end
        ST_ACC: begin
          if (still_r) begin
            vel_x_r <= '0;
            vel_y_r <= '0;
          end else begin
            vel_x_r <= clamp(sum_x);
            vel_y_r <= clamp(sum_y);
          end
          st_r <= ST_SQ;
        end
        ST_SQ: begin
          sqx_r <= mag_x_w[SPEED_W-1:0] * mag_x_w[SPEED_W-1:0];
          sqy_r <= mag_y_w[SPEED_W-1:0] * mag_y_w[SPEED_W-1:0];
          big_r <= (|mag_x_w[ROOT_W-1:SPEED_W]) || (|mag_y_w[ROOT_W-1:SPEED_W]);
          st_r  <= ST_SUM;
        end
        ST_SUM: begin
          sat_r  <= big_r || sq_sum[ROOT_W];
          rem_r  <= sq_sum[ROOT_W-1:0];
          root_r <= '0;
          bit_r  <= {2'b01, {(ROOT_W-2){1'b0}}};
          cnt_r  <= '0;
          st_r   <= ST_ROOT;
        end
        ST_ROOT: begin
          if (sat_r) begin
            st_r <= ST_DONE;
          end else begin
            if (take) begin
              rem_r  <= rem_r - trial;
              root_r <= (root_r >> 1) + bit_r;
            end else begin
              root_r <= root_r >> 1;
            end
            bit_r <= bit_r >> 2;
            cnt_r <= cnt_r + 1'b1;
            if (cnt_r == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
              st_r <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_vx_r    <= vel_x_r;
            out_vy_r    <= vel_y_r;
            out_speed_r <= sat_r ? {SPEED_W{1'b1}} : root_r[SPEED_W-1:0];
            out_still_r <= still_r;
            st_r        <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_velocity_x = out_vx_r;
  assign out_velocity_y = out_vy_r;
  assign out_speed      = out_speed_r;
  assign out_still      = out_still_r;

  // A stationary result always reports cleared velocities.
  `ZVUI_ASSERT_SAME(a_still_zero, clk, rst_n, out_valid_r && out_still_r, out_vx_r == '0 && out_vy_r == '0, "still result with nonzero velocity")
  // The trial bit stays a single bit through the root iterations.
  `ZVUI_ASSERT_SAME(a_root_onehot, clk, rst_n, st_r == ST_ROOT && !sat_r, $onehot(bit_r), "root trial bit is not one-hot")
  // Each root step advances the counter by exactly one.
  `ZVUI_ASSERT_NEXT(a_root_count, clk, rst_n, st_r == ST_ROOT && !sat_r && cnt_r != ROOT_CNT_W'(ROOT_STEPS - 1), st_r == ST_ROOT && cnt_r == $past(cnt_r) + 1'b1, "root step count skipped")
  // Accumulators change only in the update state.
  `ZVUI_ASSERT_NEXT(a_vel_hold, clk, rst_n, st_r != ST_ACC, $stable(vel_x_r) && $stable(vel_y_r), "velocity changed outside update")

endmodule

`default_nettype wire
